### hw/rtl/hxbg_pkg.sv
// package for the hashed xoshiro byte generator
// constants, sha-256 tables and the controller/datapath command structs
`default_nettype none
package hxbg_pkg;

  localparam int CHUNK_BYTES_DEF = 32;
  localparam int CNT_W = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_SEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_SEED = 1'd1;

  localparam logic [31:0] GEN_A_RST = 32'h12345678;
  localparam logic [31:0] GEN_B_RST = 32'h9abcdef0;
  localparam logic [31:0] GEN_C_RST = 32'hdeadbeef;
  localparam logic [31:0] GEN_D_RST = 32'hcafebabe;
  localparam logic [31:0] MUL_A = 32'h9E3779B1;
  localparam logic [31:0] MUL_B = 32'hBB67AE85;
  localparam logic [31:0] MUL_C = 32'h3C6EF372;
  localparam logic [31:0] MUL_D = 32'hA54FF53A;

  typedef struct packed {
    logic seed_ab;
    logic seed_cd;
    logic hash_init;
    logic hash_round;
    logic hash_final;
    logic advance;
  } hxbg_cmd_t;

  typedef struct packed {
    logic round_last;
  } hxbg_sts_t;

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] sha_h0(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/hxbg_ctrl.sv
// controller state machine for the hashed xoshiro byte generator
// depends on hxbg_pkg; drives hxbg_dp through command structs
`default_nettype none
module hxbg_ctrl #(
  parameter int CHUNK_BYTES = hxbg_pkg::CHUNK_BYTES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [hxbg_pkg::CNT_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic                          out_tlast,
  output logic [hxbg_pkg::CNT_W-1:0]    byte_idx,
  output hxbg_pkg::hxbg_cmd_t           cmd,
  input  hxbg_pkg::hxbg_sts_t           sts
);
  localparam int CW = hxbg_pkg::CNT_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SEED  = 7'b0000010,
    S_INIT  = 7'b0000100,
    S_ROUND = 7'b0001000,
    S_FIN   = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_ADV   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic seeded_r, seeded_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0] adv_r, adv_nxt;
  logic [CW-1:0] n_sat;

  assign n_sat = (in_tdata > CW'(CHUNK_BYTES)) ? CW'(CHUNK_BYTES) : in_tdata;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_EMIT);
  assign out_tlast = (idx_r + CW'(1) == n_r);
  assign byte_idx = idx_r;

  always_comb begin
    state_nxt = state_r;
    seeded_nxt = seeded_r;
    n_nxt = n_r;
    idx_nxt = idx_r;
    adv_nxt = adv_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_nxt = n_sat;
          idx_nxt = '0;
          if (!seeded_r) begin
            cmd.seed_ab = 1'b1;
            seeded_nxt = 1'b1;
            state_nxt = S_SEED;
          end else if (n_sat != '0) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_SEED: begin
        cmd.seed_cd = 1'b1;
        state_nxt = (n_r != '0) ? S_INIT : S_IDLE;
      end
      S_INIT: begin
        cmd.hash_init = 1'b1;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.hash_round = 1'b1;
        if (sts.round_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.hash_final = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_tready) begin
          idx_nxt = idx_r + CW'(1);
          if (out_tlast) begin
            adv_nxt = '0;
            state_nxt = S_ADV;
          end
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        adv_nxt = adv_r + 2'd1;
        if (adv_r == 2'd3) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seeded_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seeded_r <= seeded_nxt;
    end
    n_r <= n_nxt;
    idx_r <= idx_nxt;
    adv_r <= adv_nxt;
  end
endmodule
`default_nettype wire

### hw/rtl/hxbg_dp.sv
// datapath: generator words, seeding multipliers, sha-256 round unit, digest
// depends on hxbg_pkg; commanded by hxbg_ctrl
`default_nettype none
module hxbg_dp (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [hxbg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [31:0]              cfg_wdata,
  input  hxbg_pkg::hxbg_cmd_t           cmd,
  output hxbg_pkg::hxbg_sts_t           sts,
  input  wire logic [hxbg_pkg::CNT_W-1:0] byte_idx,
  output logic [7:0]                    rnd_byte
);
  logic [31:0] tseed_r, pseed_r;
  logic [31:0] ga_r, gb_r, gc_r, gd_r;
  logic [31:0] ga_nxt, gb_nxt, gc_nxt, gd_nxt;
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [31:0] dig_r [8];
  logic [5:0] rnd_r;

  logic [31:0] s0, s1, wn, e1, ch, t1, a0, mj;
  logic [31:0] t, xc, xd, xb, xa;

  assign sts.round_last = (rnd_r == 6'd63);

  always_comb begin
    t = gb_r << 9;
    xc = gc_r ^ ga_r;
    xd = gd_r ^ gb_r;
    xb = gb_r ^ xc;
    xa = ga_r ^ xd;
    ga_nxt = ga_r; gb_nxt = gb_r; gc_nxt = gc_r; gd_nxt = gd_r;
    if (cmd.seed_ab) begin
      ga_nxt = ga_r ^ (tseed_r * hxbg_pkg::MUL_A);
      gb_nxt = gb_r ^ (pseed_r * hxbg_pkg::MUL_B);
    end else if (cmd.seed_cd) begin
      gc_nxt = gc_r ^ (ga_r * hxbg_pkg::MUL_C);
      gd_nxt = gd_r ^ (gb_r * hxbg_pkg::MUL_D);
    end else if (cmd.advance) begin
      ga_nxt = xa;
      gb_nxt = xb;
      gc_nxt = xc ^ t;
      gd_nxt = {xd[20:0], xd[31:21]};
    end
  end

  always_comb begin
    s0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
         ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
    e1 = {v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]}
         ^ {v_r[4][24:0], v_r[4][31:25]};
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + e1 + ch + hxbg_pkg::sha_k(rnd_r) + w_r[0];
    a0 = {v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]}
         ^ {v_r[0][21:0], v_r[0][31:22]};
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tseed_r <= '0;
      pseed_r <= '0;
      ga_r <= hxbg_pkg::GEN_A_RST;
      gb_r <= hxbg_pkg::GEN_B_RST;
      gc_r <= hxbg_pkg::GEN_C_RST;
      gd_r <= hxbg_pkg::GEN_D_RST;
    end else begin
      if (cfg_we && cfg_idx == hxbg_pkg::REG_TIME_SEED) tseed_r <= cfg_wdata;
      if (cfg_we && cfg_idx == hxbg_pkg::REG_PROC_SEED) pseed_r <= cfg_wdata;
      ga_r <= ga_nxt;
      gb_r <= gb_nxt;
      gc_r <= gc_nxt;
      gd_r <= gd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_init) begin
      rnd_r <= '0;
      for (int i = 0; i < 8; i++) v_r[i] <= hxbg_pkg::sha_h0(3'(i));
      w_r[0] <= {ga_r[7:0], ga_r[15:8], ga_r[23:16], ga_r[31:24]};
      w_r[1] <= {gb_r[7:0], gb_r[15:8], gb_r[23:16], gb_r[31:24]};
      w_r[2] <= {gc_r[7:0], gc_r[15:8], gc_r[23:16], gc_r[31:24]};
      w_r[3] <= {gd_r[7:0], gd_r[15:8], gd_r[23:16], gd_r[31:24]};
      w_r[4] <= 32'h80000000;
      for (int i = 5; i < 15; i++) w_r[i] <= '0;
      w_r[15] <= 32'd128;
    end else if (cmd.hash_round) begin
      rnd_r <= rnd_r + 6'd1;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + a0 + mj;
    end
    if (cmd.hash_final) begin
      for (int i = 0; i < 8; i++) dig_r[i] <= v_r[i] + hxbg_pkg::sha_h0(3'(i));
    end
  end

  always_comb begin
    case (byte_idx[1:0])
      2'd0: rnd_byte = dig_r[byte_idx[4:2]][31:24];
      2'd1: rnd_byte = dig_r[byte_idx[4:2]][23:16];
      2'd2: rnd_byte = dig_r[byte_idx[4:2]][15:8];
      default: rnd_byte = dig_r[byte_idx[4:2]][7:0];
    endcase
  end
endmodule
`default_nettype wire

### hw/rtl/hashed_xoshiro_byte_generator_unit.sv
// sequence: accept, an extra seeding step on the first transaction, then sha-256
// (load, 64 rounds one a cycle, final add), one byte per cycle out while out_tready
// is high, and then generator advance; a zero-byte item is only accepted (and seeds
// the generator on first use)
// one item at a time
// reset (synchronous, active low) restores generator words and clears seeds
`default_nettype none
module hashed_xoshiro_byte_generator_unit #(
  parameter int CHUNK_BYTES = hxbg_pkg::CHUNK_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [5:0] byte_count
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] random_byte
  output logic             out_tlast,  // last_byte
  input  wire logic        cfg_we,
  input  wire logic [hxbg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [31:0] cfg_wdata
);
  hxbg_pkg::hxbg_cmd_t cmd;
  hxbg_pkg::hxbg_sts_t sts;
  logic [hxbg_pkg::CNT_W-1:0] byte_idx;

  hxbg_ctrl #(.CHUNK_BYTES(CHUNK_BYTES)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_tdata(in_tdata[hxbg_pkg::CNT_W-1:0]),
    .out_tvalid, .out_tready, .out_tlast, .byte_idx, .cmd, .sts
  );

  hxbg_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata, .cmd, .sts, .byte_idx,
    .rnd_byte(out_tdata)
  );
endmodule
`default_nettype wire
